// File: src/kcdl_pkg.sv
package kcdl_pkg;

    // Phase of the press detector
    typedef enum logic [2:0] {
        PH_UP     = 3'd0,
        PH_DOWN   = 3'd1,
        PH_HELD   = 3'd2,
        PH_GAP    = 3'd3,
        PH_SINGLE = 3'd4,
        PH_DOUBLE = 3'd5,
        PH_LONG   = 3'd6
    } t_phase;

    // Latched event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;
    localparam logic [1:0] EV_LONG   = 2'd3;

    // Field widths
    localparam int KEY_W  = 16;
    localparam int TICK_W = 10;
    localparam int IDX_W  = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_KEY_PATTERN = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LONG_TICKS  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_GAP_TICKS   = 2'd2;

    // Register reset values
    localparam logic [KEY_W-1:0]  KEY_PATTERN_RST = 16'd0;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 10'd300;
    localparam logic [TICK_W-1:0] GAP_TICKS_RST   = 10'd30;

    typedef struct packed {
        logic [KEY_W-1:0]  key_pattern;
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] double_gap_ticks;
    } t_cfg;

endpackage

// File: src/kcdl_cfg_regs.sv
module kcdl_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [kcdl_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [kcdl_pkg::KEY_W-1:0]  i_cfg_data,
    output logic                        o_cfg_ready,
    output kcdl_pkg::t_cfg              o_cfg
);

    kcdl_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Unknown index: write dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_pattern      <= kcdl_pkg::KEY_PATTERN_RST;
            r_cfg.long_press_ticks <= kcdl_pkg::LONG_TICKS_RST;
            r_cfg.double_gap_ticks <= kcdl_pkg::GAP_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                kcdl_pkg::CFG_KEY_PATTERN: begin
                    r_cfg.key_pattern <= i_cfg_data;
                end
                kcdl_pkg::CFG_LONG_TICKS: begin
                    r_cfg.long_press_ticks <= i_cfg_data[kcdl_pkg::TICK_W-1:0];
                end
                kcdl_pkg::CFG_GAP_TICKS: begin
                    r_cfg.double_gap_ticks <= i_cfg_data[kcdl_pkg::TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: src/kcdl_fsm.sv
module kcdl_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [kcdl_pkg::KEY_W-1:0]  i_key_bits,
    input  kcdl_pkg::t_cfg              i_cfg,
    output logic [1:0]                  o_event_next,
    output kcdl_pkg::t_phase            o_phase_next
);

    kcdl_pkg::t_phase              r_phase;
    kcdl_pkg::t_phase              n_phase;
    logic [kcdl_pkg::TICK_W-1:0]   r_tick;
    logic [kcdl_pkg::TICK_W-1:0]   n_tick;
    logic [1:0]                    r_event;
    logic [1:0]                    n_event;
    logic                          match;
    logic [kcdl_pkg::TICK_W-1:0]   tick_inc;

    assign match    = (i_key_bits == i_cfg.key_pattern);
    assign tick_inc = r_tick + kcdl_pkg::TICK_W'(1);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            kcdl_pkg::PH_UP: begin
                if (match) n_phase = kcdl_pkg::PH_DOWN;
            end
            kcdl_pkg::PH_DOWN: begin
                n_phase = match ? kcdl_pkg::PH_HELD : kcdl_pkg::PH_UP;
            end
            kcdl_pkg::PH_HELD: begin
                if (tick_inc >= i_cfg.long_press_ticks) n_phase = kcdl_pkg::PH_LONG;
                else if (!match)                        n_phase = kcdl_pkg::PH_GAP;
            end
            kcdl_pkg::PH_GAP: begin
                if (tick_inc >= i_cfg.double_gap_ticks) n_phase = kcdl_pkg::PH_SINGLE;
                else if (match)                         n_phase = kcdl_pkg::PH_DOUBLE;
            end
            kcdl_pkg::PH_SINGLE: begin
                n_phase = kcdl_pkg::PH_UP;
            end
            kcdl_pkg::PH_DOUBLE, kcdl_pkg::PH_LONG: begin
                if (!match) n_phase = kcdl_pkg::PH_UP;
            end
            default: begin
                n_phase = kcdl_pkg::PH_UP;
            end
        endcase
    end

    // Counter and event
    always_comb begin
        n_tick  = r_tick;
        n_event = r_event;
        case (r_phase)
            kcdl_pkg::PH_HELD: begin
                if (tick_inc >= i_cfg.long_press_ticks || !match) n_tick = '0;
                else                                              n_tick = tick_inc;
            end
            kcdl_pkg::PH_GAP: begin
                if (tick_inc >= i_cfg.double_gap_ticks || match) n_tick = '0;
                else                                             n_tick = tick_inc;
            end
            kcdl_pkg::PH_SINGLE: n_event = kcdl_pkg::EV_SINGLE;
            kcdl_pkg::PH_DOUBLE: n_event = kcdl_pkg::EV_DOUBLE;
            kcdl_pkg::PH_LONG:   n_event = kcdl_pkg::EV_LONG;
            default: begin
            end
        endcase
    end

    assign o_event_next = n_event;
    assign o_phase_next = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kcdl_pkg::PH_UP;
            r_tick  <= '0;
            r_event <= kcdl_pkg::EV_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_event <= n_event;
        end
    end

    // Counter only runs while held or in the click gap
    a_tick_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != kcdl_pkg::PH_HELD && r_phase != kcdl_pkg::PH_GAP) |-> (r_tick == '0))
        else $error("tick counter nonzero outside held/gap");

    // Event only latched out of a reporting phase
    a_event_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_event != $past(r_event)) |->
            ($past(r_phase) == kcdl_pkg::PH_SINGLE || $past(r_phase) == kcdl_pkg::PH_DOUBLE
             || $past(r_phase) == kcdl_pkg::PH_LONG))
        else $error("event changed outside a reporting phase");

    // Long press only entered from held
    a_long_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_phase == kcdl_pkg::PH_LONG) && ($past(r_phase) != kcdl_pkg::PH_LONG)
            |-> ($past(r_phase) == kcdl_pkg::PH_HELD))
        else $error("long phase entered from wrong phase");

    // Double click only entered from click gap
    a_double_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_phase == kcdl_pkg::PH_DOUBLE)
            && ($past(r_phase) != kcdl_pkg::PH_DOUBLE)
            |-> ($past(r_phase) == kcdl_pkg::PH_GAP))
        else $error("double phase entered from wrong phase");

endmodule

// File: src/key_click_double_long_detector_top.sv
// An input word passes through the input register, then the result register, to reach its result.
// Throughput: one key word per cycle while i_stall stays low; the phase update is a single compare-and-increment.
// While a result waits on i_stall the input register takes one more word, then o_stall rises.
// Reset (i_rst_n low, synchronous): phase up, tick counter and event cleared,
// pipeline empty, key_pattern 0, long_press_ticks 300, double_gap_ticks 30.
module key_click_double_long_detector_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // scan tick input
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [kcdl_pkg::KEY_W-1:0]  i_key_bits,
    // result output
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_last_event,
    output logic [2:0]                  o_phase,
    // register writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kcdl_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [kcdl_pkg::KEY_W-1:0]  i_cfg_data
);

    kcdl_pkg::t_cfg                cfg;

    // Input register
    logic                          r_in_valid;
    logic [kcdl_pkg::KEY_W-1:0]    r_key_bits;

    // Result register
    logic                          r_out_valid;
    logic [1:0]                    r_last_event;
    kcdl_pkg::t_phase              r_phase;

    logic                          out_free;
    logic                          step;
    logic                          in_take;
    logic [1:0]                    event_next;
    kcdl_pkg::t_phase              phase_next;

    kcdl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // Result slot frees when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_stall;
    // The held word advances into the state machine and the result register
    assign step     = r_in_valid && out_free;
    // Input register takes a word when empty or when its word moves on
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    kcdl_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_key_bits   (r_key_bits),
        .i_cfg        (cfg),
        .o_event_next (event_next),
        .o_phase_next (phase_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take)       r_in_valid <= 1'b1;
            else if (step)     r_in_valid <= 1'b0;
            if (step)          r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_key_bits <= i_key_bits;
        end
        if (step) begin
            r_last_event <= event_next;
            r_phase      <= phase_next;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_last_event = r_last_event;
    assign o_phase      = 3'(r_phase);

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Self-checking bench for the click / double-click / long-press detector.
    // A directed table walks the basic phase chain and the limit corner cases,
    // then randomized phases with fresh register settings drive mostly
    // well-formed press/release sequences. Results are compared against an
    // in-bench copy of the phase machine, or typed-in reports for fixed rows.

    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [kcdl_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int MAX_SHOWN      = 10;   // mismatches printed in full
    localparam int SQUEEZE_CYCLES = 200;  // one long receiver hold-off
    localparam int PLAN_N         = 30;   // rows in the directed table
    localparam int PHASES         = 8;    // random phases with small limits
    localparam int PHASE_KEYS     = 50;   // at least this many scan ticks per random phase
    localparam int TAIL_CYCLES    = 8;    // idle wait past drain before the verdict

    // What the block reports for one scan tick.
    typedef struct packed {
        logic [1:0]       ev;
        kcdl_pkg::t_phase ph;
    } t_report;

    // One directed row: either a register write or a key word. Key rows with
    // fixed set carry their expected report typed in; others use the tracker.
    typedef struct packed {
        logic                       is_cfg;
        logic [kcdl_pkg::IDX_W-1:0] idx;
        logic [kcdl_pkg::KEY_W-1:0] word;
        logic                       fixed;
        logic [1:0]                 ev;
        kcdl_pkg::t_phase           ph;
    } t_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [kcdl_pkg::KEY_W-1:0]  i_key_bits;
    logic                        o_valid;
    logic                        i_stall;
    logic [1:0]                  o_last_event;
    logic [2:0]                  o_phase;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [kcdl_pkg::IDX_W-1:0]  i_cfg_index;
    logic [kcdl_pkg::KEY_W-1:0]  i_cfg_data;

    // Bench copy of the detector: registers and machine state.
    kcdl_pkg::t_cfg              det_cfg;
    kcdl_pkg::t_phase            det_phase;
    logic [kcdl_pkg::TICK_W-1:0] det_ticks;
    logic [1:0]                  det_event;

    // Reports owed by the block, oldest first.
    t_report           due_reports[$];

    t_row              plan [PLAN_N];
    int unsigned       n_keys;
    int unsigned       n_fail;
    bit                calm;          // sender offers back to back when set
    bit                squeeze;       // asks the receiver for its long hold-off

    key_click_double_long_detector_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key_bits   (i_key_bits),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_last_event (o_last_event),
        .o_phase      (o_phase),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // One scan tick through the phase machine. Counter bumps before the
    // compare, so a zero limit behaves like a limit of one.
    function automatic t_report press_step(input logic [kcdl_pkg::KEY_W-1:0] word);
        t_report r;
        logic    hit;
        hit = (word == det_cfg.key_pattern);
        case (det_phase)
            kcdl_pkg::PH_UP: begin
                if (hit) det_phase = kcdl_pkg::PH_DOWN;
            end
            kcdl_pkg::PH_DOWN: begin
                det_phase = hit ? kcdl_pkg::PH_HELD : kcdl_pkg::PH_UP;
            end
            kcdl_pkg::PH_HELD: begin
                det_ticks = det_ticks + kcdl_pkg::TICK_W'(1);
                if (det_ticks < det_cfg.long_press_ticks) begin
                    if (!hit) begin
                        det_ticks = '0;
                        det_phase = kcdl_pkg::PH_GAP;
                    end
                end else begin
                    det_ticks = '0;
                    det_phase = kcdl_pkg::PH_LONG;
                end
            end
            kcdl_pkg::PH_GAP: begin
                det_ticks = det_ticks + kcdl_pkg::TICK_W'(1);
                if (det_ticks < det_cfg.double_gap_ticks) begin
                    if (hit) begin
                        det_ticks = '0;
                        det_phase = kcdl_pkg::PH_DOUBLE;
                    end
                end else begin
                    det_ticks = '0;
                    det_phase = kcdl_pkg::PH_SINGLE;
                end
            end
            kcdl_pkg::PH_SINGLE: begin
                det_event = kcdl_pkg::EV_SINGLE;
                det_phase = kcdl_pkg::PH_UP;
            end
            kcdl_pkg::PH_DOUBLE: begin
                det_event = kcdl_pkg::EV_DOUBLE;
                if (!hit) det_phase = kcdl_pkg::PH_UP;
            end
            kcdl_pkg::PH_LONG: begin
                det_event = kcdl_pkg::EV_LONG;
                if (!hit) det_phase = kcdl_pkg::PH_UP;
            end
            default: begin
                det_phase = kcdl_pkg::PH_UP;
            end
        endcase
        r.ev = det_event;
        r.ph = det_phase;
        return r;
    endfunction

    // Random word that does not match the key; a third are one-bit near misses.
    function automatic logic [kcdl_pkg::KEY_W-1:0] miss_word();
        logic [kcdl_pkg::KEY_W-1:0] w;
        if ($urandom_range(0, 2) == 0) begin
            w = det_cfg.key_pattern ^ (16'd1 << $urandom_range(0, kcdl_pkg::KEY_W - 1));
        end else begin
            w = 16'($urandom);
            if (w == det_cfg.key_pattern) w = ~w;
        end
        return w;
    endfunction

    task automatic report_fail(input string what, input int unsigned want_v,
                               input int unsigned got_v);
        n_fail++;
        if (n_fail <= MAX_SHOWN) begin
            $display("mismatch %0s: expected %0d, got %0d at %0t",
                     what, want_v, got_v, $realtime);
        end
    endtask

    // Offer one key word, wait for its transfer, book the expected report,
    // then idle the sender for a random gap.
    task automatic send_key(input logic [kcdl_pkg::KEY_W-1:0] word, input logic fixed,
                            input logic [1:0] fix_ev, input kcdl_pkg::t_phase fix_ph);
        t_report     pred;
        int unsigned gap;
        int unsigned roll;
        i_cfg_valid <= 1'b0;
        i_valid     <= 1'b1;
        i_key_bits  <= word;
        do @(posedge i_clk); while (o_stall);
        pred = press_step(word);
        if (fixed) begin
            pred.ev = fix_ev;
            pred.ph = fix_ph;
        end
        due_reports.push_back(pred);
        n_keys++;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (!calm) begin
            if (roll >= 88)      gap = $urandom_range(6, 30);
            else if (roll >= 50) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic hold_key(input int unsigned n);
        repeat (n) send_key(det_cfg.key_pattern, 1'b0, kcdl_pkg::EV_NONE, kcdl_pkg::PH_UP);
    endtask

    task automatic drop_key(input int unsigned n);
        repeat (n) send_key(miss_word(), 1'b0, kcdl_pkg::EV_NONE, kcdl_pkg::PH_UP);
    endtask

    task automatic key_idle();
        i_valid <= 1'b0;
    endtask

    // Register write, only once every owed report has come back.
    // Valid is left high; the next key transfer lowers it.
    task automatic write_reg(input logic [kcdl_pkg::IDX_W-1:0] idx,
                             input logic [kcdl_pkg::KEY_W-1:0] data);
        key_idle();
        while (due_reports.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            kcdl_pkg::CFG_KEY_PATTERN: det_cfg.key_pattern      = data;
            kcdl_pkg::CFG_LONG_TICKS:  det_cfg.long_press_ticks = data[kcdl_pkg::TICK_W-1:0];
            kcdl_pkg::CFG_GAP_TICKS:   det_cfg.double_gap_ticks = data[kcdl_pkg::TICK_W-1:0];
            default: ;
        endcase
    endtask

    // Result checker: every transfer out must match the oldest owed report.
    always @(posedge i_clk) begin : result_check
        t_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_reports.size() == 0) begin
                report_fail("result with none owed, phase", 0, o_phase);
            end else begin
                want = due_reports.pop_front();
                if (o_last_event !== want.ev) report_fail("last_event", want.ev, o_last_event);
                if (o_phase !== want.ph) report_fail("phase", want.ph, o_phase);
            end
        end
    end

    // Receiver: runs of no stall, choppy stalls and the odd long stall,
    // plus one long hold-off once the random part starts.
    initial begin : rx_stall
        int unsigned len;
        int unsigned roll;
        int unsigned n;
        logic        v;
        bit          squeezed;
        squeezed = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (squeeze && !squeezed) begin
                // hold off while the sender keeps offering: block fills and stalls
                for (n = 0; n < SQUEEZE_CYCLES; n++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
                squeezed = 1'b1;
            end
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
                len = $urandom_range(1, 24);
                repeat (len) begin
                    i_stall <= 1'b0;
                    @(posedge i_clk);
                end
            end else if (roll < 8) begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    v = 1'($urandom_range(0, 1));
                    i_stall <= v;
                    @(posedge i_clk);
                end
            end else begin
                len = (roll == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (len) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned p;
        int unsigned stop_at;
        int unsigned shape;
        int unsigned lim_l;
        int unsigned lim_g;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_key_bits  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= kcdl_pkg::CFG_KEY_PATTERN;
        i_cfg_data  <= '0;
        det_cfg.key_pattern      = kcdl_pkg::KEY_PATTERN_RST;
        det_cfg.long_press_ticks = kcdl_pkg::LONG_TICKS_RST;
        det_cfg.double_gap_ticks = kcdl_pkg::GAP_TICKS_RST;
        det_phase = kcdl_pkg::PH_UP;
        det_ticks = '0;
        det_event = kcdl_pkg::EV_NONE;
        n_keys    = 0;
        n_fail    = 0;
        calm      = 1'b0;
        squeeze   = 1'b0;

        // Directed table. Reset config first: pattern 0, limits 300 / 30.
        plan = '{
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b1,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b1,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_DOWN},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b1,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_HELD},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b1,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_GAP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b1,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_DOUBLE},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b1,
              kcdl_pkg::EV_DOUBLE, kcdl_pkg::PH_DOUBLE},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b1,
              kcdl_pkg::EV_DOUBLE, kcdl_pkg::PH_UP},
            // all-ones pattern, both limits zero
            '{1'b1, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b1, kcdl_pkg::CFG_LONG_TICKS,  16'h0000, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b1, kcdl_pkg::CFG_GAP_TICKS,   16'h0000, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b1,
              kcdl_pkg::EV_DOUBLE, kcdl_pkg::PH_DOWN},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b1,
              kcdl_pkg::EV_DOUBLE, kcdl_pkg::PH_HELD},
            // zero long limit: first held tick is already long
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b1,
              kcdl_pkg::EV_DOUBLE, kcdl_pkg::PH_LONG},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b1,
              kcdl_pkg::EV_LONG,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h7FFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            // long limit from all-ones data: upper bits dropped, 1023
            '{1'b1, kcdl_pkg::CFG_LONG_TICKS,  16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            // zero gap limit: first gap tick expires as a single click
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            // write to the unused index must change nothing
            '{1'b1, CFG_SPARE,                 16'h0000, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b1, kcdl_pkg::CFG_GAP_TICKS,   16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0001, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'hFFFF, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP},
            '{1'b0, kcdl_pkg::CFG_KEY_PATTERN, 16'h0000, 1'b0,
              kcdl_pkg::EV_NONE,   kcdl_pkg::PH_UP}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_N; r++) begin
            if (plan[r].is_cfg) begin
                write_reg(plan[r].idx, plan[r].word);
            end else begin
                send_key(plan[r].word, plan[r].fixed, plan[r].ev, plan[r].ph);
            end
        end

        // Random phases, small limits so sequences cross every boundary often.
        for (p = 0; p < PHASES; p++) begin
            write_reg(kcdl_pkg::CFG_KEY_PATTERN, (p == 0) ? 16'h0000 :
                                                 (p == 1) ? 16'hFFFF : 16'($urandom));
            write_reg(kcdl_pkg::CFG_LONG_TICKS, {6'($urandom), 10'($urandom_range(0, 12))});
            write_reg(kcdl_pkg::CFG_GAP_TICKS,  {6'($urandom), 10'($urandom_range(0, 10))});
            if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, 16'($urandom));
            // long receiver hold-off lands while this phase keeps offering keys
            if (p == 0) squeeze = 1'b1;
            lim_l   = det_cfg.long_press_ticks;
            lim_g   = det_cfg.double_gap_ticks;
            stop_at = n_keys + PHASE_KEYS;
            while (n_keys < stop_at) begin
                calm  = ($urandom_range(0, 3) == 0);
                shape = $urandom_range(0, 9);
                case (shape)
                    0, 1, 2: begin
                        // click, release lengths around the gap limit
                        hold_key($urandom_range(1, lim_l + 3));
                        drop_key($urandom_range(1, lim_g + 4));
                    end
                    3, 4, 5: begin
                        // double-click attempt
                        hold_key($urandom_range(2, lim_l + 1));
                        drop_key($urandom_range(1, lim_g + 1));
                        hold_key($urandom_range(1, 4));
                        drop_key($urandom_range(1, 3));
                    end
                    6: begin
                        hold_key(lim_l + $urandom_range(2, 6));
                        drop_key($urandom_range(1, 3));
                    end
                    7, 8: begin
                        repeat ($urandom_range(1, 6)) begin
                            send_key(($urandom_range(0, 3) == 0) ? det_cfg.key_pattern
                                                                 : 16'($urandom),
                                     1'b0, kcdl_pkg::EV_NONE, kcdl_pkg::PH_UP);
                        end
                    end
                    default: begin
                        // chatter: one-tick presses and releases
                        repeat ($urandom_range(2, 8)) begin
                            hold_key(1);
                            drop_key(1);
                        end
                    end
                endcase
            end
        end

        // Widest limits from all-ones writes, then a mid-size long limit run out.
        calm = 1'b0;
        write_reg(kcdl_pkg::CFG_KEY_PATTERN, 16'($urandom));
        write_reg(kcdl_pkg::CFG_LONG_TICKS, 16'hFFFF);
        write_reg(kcdl_pkg::CFG_GAP_TICKS, 16'hFFFF);
        hold_key(5);
        drop_key(5);
        hold_key(3);
        drop_key(2);
        hold_key(4);
        drop_key(2);
        write_reg(kcdl_pkg::CFG_LONG_TICKS, 16'd40);
        hold_key(43);
        drop_key(2);

        key_idle();
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
src/kcdl_pkg.sv
src/kcdl_cfg_regs.sv
src/kcdl_fsm.sv
src/key_click_double_long_detector_top.sv
bench/testbench.sv
